// ===== design/situ_pkg.sv =====
// Shared types and constants for the seen-ID table update unit.
`timescale 1ns / 1ps
`default_nettype none

package situ_pkg;

  // Result status codes as they appear on update_status
  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_INSERT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Saturation point of the per-entry sighting count
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Depth of the operation queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified operation handed from front to back (slot index travels beside it)
  typedef struct packed {
    status_t     status;
    logic [7:0]  level;
    logic [7:0]  icon;
    logic [31:0] now;
  } situ_op_t;

endpackage

`default_nettype wire

// ===== design/situ_front.sv =====
// Front end: accepts sightings, searches the key CAM and classifies hit, insert or full.
`timescale 1ns / 1ps
`default_nettype none

module situ_front
  import situ_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32,
  parameter int SLOT_W        = 5,
  parameter int USED_W        = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [31:0]       sighting_id,
  input  wire logic [7:0]        peer_level,
  input  wire logic [7:0]        peer_icon,
  input  wire logic [31:0]       time_now,
  input  wire logic              q_full,
  output logic                   push,
  output situ_op_t               push_op,
  output logic [SLOT_W-1:0]      push_slot
);

  logic                     cls_valid;
  logic [USED_W-1:0]        entry_used;
  logic [TABLE_ENTRIES-1:0] used_vec;
  logic [31:0]              key_mem [TABLE_ENTRIES];

  logic [31:0]              id_q;
  logic [7:0]               level_q;
  logic [7:0]               icon_q;
  logic [31:0]              now_q;
  logic [TABLE_ENTRIES-1:0] match_q;

  logic [TABLE_ENTRIES-1:0] match_now;
  logic                     accept;
  logic                     hit;
  logic                     full;
  logic                     is_insert;
  logic [SLOT_W-1:0]        hit_slot;
  logic [SLOT_W-1:0]        ins_slot;

  // Lowest set bit wins
  function automatic logic [SLOT_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  assign busy   = cls_valid || q_full;
  assign accept = start && !busy;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_now[i] = used_vec[i] && (key_mem[i] == sighting_id);
    end
  end

  assign hit       = |match_q;
  assign full      = (entry_used == USED_W'(TABLE_ENTRIES));
  assign is_insert = cls_valid && !hit && !full;
  assign hit_slot  = first_set(match_q);
  assign ins_slot  = entry_used[SLOT_W-1:0];

  always_comb begin
    push_op.level = level_q;
    push_op.icon  = icon_q;
    push_op.now   = now_q;
    priority if (hit) begin
      push_op.status = ST_HIT;
      push_slot      = hit_slot;
    end else if (full) begin
      push_op.status = ST_FULL;
      push_slot      = '0;
    end else begin
      push_op.status = ST_INSERT;
      push_slot      = ins_slot;
    end
  end

  assign push = cls_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid  <= 1'b0;
      entry_used <= '0;
      used_vec   <= '0;
    end else begin
      cls_valid <= accept;
      if (is_insert) begin
        used_vec[ins_slot] <= 1'b1;
        entry_used         <= entry_used + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_q    <= sighting_id;
      level_q <= peer_level;
      icon_q  <= peer_icon;
      now_q   <= time_now;
      match_q <= match_now;
    end
    if (is_insert) begin
      key_mem[ins_slot] <= id_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/situ_queue.sv =====
// Short in-order queue of classified operations between front and back.
`timescale 1ns / 1ps
`default_nettype none

module situ_queue
  import situ_pkg::*;
#(
  parameter int SLOT_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire situ_op_t          push_op,
  input  wire logic [SLOT_W-1:0] push_slot,
  input  wire logic              pop,
  output situ_op_t               head_op,
  output logic [SLOT_W-1:0]      head_slot,
  output logic                   full,
  output logic                   empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  situ_op_t          op_mem   [QUEUE_DEPTH];
  logic [SLOT_W-1:0] slot_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_op   = op_mem[rd_ptr];
  assign head_slot = slot_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wr_ptr]   <= push_op;
      slot_mem[wr_ptr] <= push_slot;
    end
  end

endmodule

`default_nettype wire

// ===== design/situ_back.sv =====
// Back end: reads the entry stores, applies the update and issues the result word.
`timescale 1ns / 1ps
`default_nettype none

module situ_back
  import situ_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32,
  parameter int SLOT_W        = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire situ_op_t          head_op,
  input  wire logic [SLOT_W-1:0] head_slot,
  output logic                   pop,
  output logic                   done,
  output logic [4:0]             slot_index,
  output logic [1:0]             update_status,
  output logic [15:0]            hit_count,
  output logic [31:0]            first_time
);

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  bk_state_t         state;
  situ_op_t          op;
  logic [SLOT_W-1:0] slot;
  logic [15:0]       count_rd;
  logic [31:0]       first_rd;

  logic [15:0] count_mem [TABLE_ENTRIES];
  logic [31:0] first_mem [TABLE_ENTRIES];
  logic [31:0] last_mem  [TABLE_ENTRIES];
  logic [7:0]  level_mem [TABLE_ENTRIES];
  logic [7:0]  icon_mem  [TABLE_ENTRIES];

  logic [15:0]       count_next;
  logic [SLOT_W+4:0] slot_ext;
  logic              exec;

  assign pop        = (state == BK_IDLE) && !q_empty;
  assign exec       = (state == BK_EXEC);
  assign count_next = (count_rd == COUNT_MAX) ? count_rd : count_rd + 16'd1;
  assign slot_ext   = {5'd0, slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        BK_IDLE: begin
          if (pop) begin
            state <= BK_EXEC;
          end
        end
        BK_EXEC: begin
          state         <= BK_IDLE;
          done          <= 1'b1;
          update_status <= op.status;
          unique case (op.status)
            ST_HIT: begin
              slot_index <= slot_ext[4:0];
              hit_count  <= count_next;
              first_time <= first_rd;
            end
            ST_INSERT: begin
              slot_index <= slot_ext[4:0];
              hit_count  <= 16'd1;
              first_time <= op.now;
            end
            default: begin
              slot_index <= 5'd0;
              hit_count  <= 16'd0;
              first_time <= 32'd0;
            end
          endcase
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op       <= head_op;
      slot     <= head_slot;
      count_rd <= count_mem[head_slot];
      first_rd <= first_mem[head_slot];
    end
    if (exec && (op.status == ST_HIT)) begin
      count_mem[slot] <= count_next;
      last_mem[slot]  <= op.now;
      level_mem[slot] <= op.level;
    end else if (exec && (op.status == ST_INSERT)) begin
      count_mem[slot] <= 16'd1;
      first_mem[slot] <= op.now;
      last_mem[slot]  <= op.now;
      level_mem[slot] <= op.level;
      icon_mem[slot]  <= op.icon;
    end
  end

endmodule

`default_nettype wire

// ===== design/seen_id_table_update_unit.sv =====
// Top level of the seen-ID table update unit: front, queue and back wired together.
// Path: front classify registers, queue, back operand registers, result registers.
// The front's compare-then-classify pair takes no new sighting while one is pending
//   or the queue is full; the back finishes its read-then-write on the entry stores before its next pop.
// Reset clears the fill count, slot valid bits, queue and state; entry stores are
//   not cleared and their contents are only used once their slot has been filled.
// The receiver cannot stall: done pulses for one cycle per word.
`timescale 1ns / 1ps
`default_nettype none

module seen_id_table_update_unit
  import situ_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] sighting_id,
  input  wire logic [7:0]  peer_level,
  input  wire logic [7:0]  peer_icon,
  input  wire logic [31:0] time_now,
  output logic             done,
  output logic [4:0]       slot_index,
  output logic [1:0]       update_status,
  output logic [15:0]      hit_count,
  output logic [31:0]      first_time
);

  // Slot index width; a one-entry table still carries one index bit
  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // Fill count must be able to hold TABLE_ENTRIES itself
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  situ_op_t          push_op;
  situ_op_t          head_op;
  logic [SLOT_W-1:0] push_slot;
  logic [SLOT_W-1:0] head_slot;

  // Front: take a word while no classification is pending and the queue has room,
  // compare the key against every filled slot, then classify on the next cycle
  // and claim a new slot on a miss while the table is not full.
  situ_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SLOT_W        (SLOT_W),
    .USED_W        (USED_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sighting_id (sighting_id),
    .peer_level  (peer_level),
    .peer_icon   (peer_icon),
    .time_now    (time_now),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op),
    .push_slot   (push_slot)
  );

  // Queue: hold classified operations in order so front and back stall apart.
  situ_queue #(
    .SLOT_W (SLOT_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .push_slot (push_slot),
    .pop       (pop),
    .head_op   (head_op),
    .head_slot (head_slot),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: read count and first-seen time, write the updated entry, and drive
  // the result word from registers.
  situ_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SLOT_W        (SLOT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head_op       (head_op),
    .head_slot     (head_slot),
    .pop           (pop),
    .done          (done),
    .slot_index    (slot_index),
    .update_status (update_status),
    .hit_count     (hit_count),
    .first_time    (first_time)
  );

endmodule

`default_nettype wire

// ===== design/situ_checker.sv =====
// Port-level checker for the seen-ID table update unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module situ_checker
  import situ_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        done,
  input wire logic [4:0]  slot_index,
  input wire logic [1:0]  update_status,
  input wire logic [15:0] hit_count,
  input wire logic [31:0] first_time
);

  // No result word in the cycle after reset
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result word right after reset");

  // Result words never come in consecutive cycles
  a_done_spacing: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result words in consecutive cycles");

  // A dropped sighting reports zero slot, count and time
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (update_status == ST_FULL)) |->
      ((slot_index == 5'd0) && (hit_count == 16'd0) && (first_time == 32'd0)))
    else $error("full result with nonzero fields");

  // A fresh entry always starts at count one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && (update_status == ST_INSERT)) |-> (hit_count == 16'd1))
    else $error("insert result with count other than one");

  // A hit counts at least the insert plus this sighting
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (done && (update_status == ST_HIT)) |-> (hit_count >= 16'd2))
    else $error("hit result with count below two");

endmodule

bind seen_id_table_update_unit situ_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .done          (done),
  .slot_index    (slot_index),
  .update_status (update_status),
  .hit_count     (hit_count),
  .first_time    (first_time)
);

`default_nettype wire
